@@ hdl/slsr_pkg.sv @@
// shared types, constants and helpers of the sprite line select and render block
package slsr_pkg;

   localparam int MEM_BYTES     = 131072;
   localparam int MEM_AW        = $clog2(MEM_BYTES);
   localparam int LINE_SPRITES  = 8;
   localparam int SLOT_W        = $clog2(LINE_SPRITES);
   localparam int CNT_W         = $clog2(LINE_SPRITES + 1);
   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int MODE1_KEEP    = 4;
   localparam int ADDR_W        = 17;
   localparam int CSR_IDX_W     = 3;

   localparam logic [7:0]        END_Y_M1     = 8'hd0;
   localparam logic [7:0]        END_Y_M2     = 8'hd8;
   localparam logic [7:0]        Y_WRAP       = 8'he0;
   localparam logic [ADDR_W-1:0] ATTR_MASK_M1 = 17'h03f80;
   localparam logic [ADDR_W-1:0] ATTR_MASK_M2 = 17'h1fe00;
   localparam logic [ADDR_W-1:0] CT_MASK      = 17'h1fc00;
   localparam logic [ADDR_W-1:0] ADDR_MASK_M1 = 17'h03fff;
   localparam logic [ADDR_W-1:0] ADDR_MASK_M2 = 17'h1ffff;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_SCAN  = 2'd1,
      KIND_PIXEL = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] mem_address;
      logic [7:0]        mem_data;
      logic [7:0]        hpos;
      logic [7:0]        vpos;
   } req_type;

   typedef struct packed {
      logic [3:0] color;
      logic       collision;
      logic       overflow;
      logic [4:0] overflow_index;
   } rsp_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DISPLAY_MODE   = 3'd0,
      CSR_ZOOM_ENABLE    = 3'd1,
      CSR_LARGE_SIZE     = 3'd2,
      CSR_SPRITES_OFF    = 3'd3,
      CSR_ATTRIBUTE_BASE = 3'd4,
      CSR_PATTERN_BASE   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      SPR_NONE  = 2'd0,
      SPR_MODE1 = 2'd1,
      SPR_MODE2 = 2'd2
   } spr_mode_type;

   typedef enum logic [2:0] {
      RD_ATTR_Y,
      RD_ATTR_X,
      RD_ATTR_PAT,
      RD_ATTR_COL,
      RD_COLOR_TABLE,
      RD_PATTERN
   } rd_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_Y,
      ST_SCAN_X,
      ST_SCAN_PAT,
      ST_SCAN_ATTR,
      ST_SCAN_EVAL,
      ST_SCAN_CT,
      ST_PIX_TEST,
      ST_PIX_BIT,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       mem_wr;
      rd_sel_type rd_sel;
      logic       scan_start;
      logic       cap_y;
      logic       cap_x;
      logic       cap_pat;
      logic       scan_next;
      logic       store_obj;
      logic       set_ovf;
      logic       pix_next;
      logic       pix_mark;
      logic       take_color;
      logic       set_coll;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      kind_type     kind;
      spr_mode_type mode;
      logic         sprites_off;
      logic         end_hit;
      logic         in_range;
      logic         full;
      logic         last_entry;
      logic         pix_done;
      logic         pix_hit;
      logic         opaque;
      logic         color_nz;
      logic         out_free;
   } status_type;

   function automatic spr_mode_type sprite_mode(input logic [4:0] code);
      spr_mode_type m;
      case (code) inside
         5'd0, 5'd2, 5'd4:                  m = SPR_MODE1;
         5'd8, 5'd12, 5'd16, 5'd20, 5'd28:  m = SPR_MODE2;
         default:                           m = SPR_NONE;
      endcase
      return m;
   endfunction

endpackage

@@ hdl/slsr_ctrl.sv @@
// controller state machine that sequences memory writes, line scans and pixel queries
module slsr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  slsr_pkg::status_type sts,
   output slsr_pkg::cmd_type   cmd
);
   import slsr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_PATTERN;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.kind)
               KIND_WRITE: begin
                  cmd.mem_wr = 1'b1;
                  state_in   = ST_RESPOND;
               end
               KIND_SCAN: begin
                  if (sts.mode == SPR_NONE) begin
                     state_in = ST_RESPOND;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in = (sts.mode == SPR_MODE2 && sts.sprites_off) ?
                                ST_RESPOND : ST_SCAN_Y;
                  end
               end
               KIND_PIXEL: begin
                  state_in = (sts.mode == SPR_NONE) ? ST_RESPOND : ST_PIX_TEST;
               end
               default: begin
                  state_in = ST_RESPOND;
               end
            endcase
         end
         // attribute bytes are fetched back to back, each captured in the cycle after it is read
         ST_SCAN_Y: begin
            cmd.rd_sel = RD_ATTR_Y;
            state_in   = ST_SCAN_X;
         end
         ST_SCAN_X: begin
            cmd.rd_sel = RD_ATTR_X;
            cmd.cap_y  = 1'b1;
            state_in   = ST_SCAN_PAT;
         end
         ST_SCAN_PAT: begin
            cmd.rd_sel = RD_ATTR_PAT;
            cmd.cap_x  = 1'b1;
            state_in   = ST_SCAN_ATTR;
         end
         ST_SCAN_ATTR: begin
            cmd.rd_sel  = RD_ATTR_COL;
            cmd.cap_pat = 1'b1;
            state_in    = ST_SCAN_EVAL;
         end
         ST_SCAN_EVAL: begin
            if (sts.end_hit) begin
               state_in = ST_RESPOND;
            end else if (!sts.in_range) begin
               cmd.scan_next = 1'b1;
               state_in = sts.last_entry ? ST_RESPOND : ST_SCAN_Y;
            end else if (sts.full) begin
               cmd.set_ovf = 1'b1;
               state_in    = ST_RESPOND;
            end else if (sts.mode == SPR_MODE2) begin
               cmd.rd_sel = RD_COLOR_TABLE;
               state_in   = ST_SCAN_CT;
            end else begin
               cmd.store_obj = 1'b1;
               cmd.scan_next = 1'b1;
               state_in = sts.last_entry ? ST_RESPOND : ST_SCAN_Y;
            end
         end
         ST_SCAN_CT: begin
            cmd.store_obj = 1'b1;
            cmd.scan_next = 1'b1;
            state_in = sts.last_entry ? ST_RESPOND : ST_SCAN_Y;
         end
         ST_PIX_TEST: begin
            if (sts.pix_done) begin
               state_in = ST_RESPOND;
            end else if (!sts.pix_hit) begin
               cmd.pix_next = 1'b1;
            end else begin
               cmd.rd_sel   = RD_PATTERN;
               cmd.pix_mark = 1'b1;
               state_in     = ST_PIX_BIT;
            end
         end
         ST_PIX_BIT: begin
            if (sts.opaque && sts.color_nz) begin
               cmd.set_coll = 1'b1;
               state_in     = ST_RESPOND;
            end else begin
               cmd.take_color = sts.opaque;
               cmd.pix_next   = 1'b1;
               state_in       = ST_PIX_TEST;
            end
         end
         ST_RESPOND: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/slsr_dp.sv @@
// datapath: video memory, registers, held sprite slots, flags and result register
module slsr_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  slsr_pkg::req_type                  req_data,
   input  logic                               csr_we,
   input  logic [slsr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [slsr_pkg::ADDR_W-1:0]        csr_wdata,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output slsr_pkg::rsp_type                  rsp_data,
   input  slsr_pkg::cmd_type                  cmd,
   output slsr_pkg::status_type               sts
);
   import slsr_pkg::*;

   logic [7:0] video_mem [MEM_BYTES];

   logic [4:0]        display_mode_ff;
   logic              zoom_ff, large_ff, off_ff;
   logic [ADDR_W-1:0] attr_base_ff, pat_base_ff;

   req_type           req_ff;
   logic [7:0]        rdata_ff;
   logic [ADDR_W-1:0] scan_addr_ff;
   logic [IDX_W-1:0]  index_ff;
   logic signed [9:0] y_ff;
   logic              yend_ff;
   logic [7:0]        x_ff, pat_ff;
   logic [CNT_W-1:0]  count_ff, pix_i_ff;
   logic [2:0]        px_bit_ff;
   logic [3:0]        color_ff;
   logic              collision_ff, overflow_ff;
   logic [4:0]        ovf_idx_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic signed [9:0] obj_x_ff   [LINE_SPRITES];
   logic signed [9:0] obj_y_ff   [LINE_SPRITES];
   logic [7:0]        obj_pat_ff [LINE_SPRITES];
   logic [3:0]        obj_col_ff [LINE_SPRITES];

   spr_mode_type      mode;
   logic [ADDR_W-1:0] addr_mask, rd_addr, ct_addr, pat_addr;
   logic [4:0]        lim;
   logic signed [9:0] lim_s, v_s, h_s, y_calc, dy, x_sel, dx, dy_sel, x_store;
   logic [SLOT_W-1:0] sel, slot;
   logic [3:0]        px, py, pyl;
   logic [CNT_W-1:0]  keep;

   assign mode      = sprite_mode(display_mode_ff);
   assign addr_mask = (mode == SPR_MODE1) ? ADDR_MASK_M1 : ADDR_MASK_M2;
   assign lim       = zoom_ff ? (large_ff ? 5'd31 : 5'd15) : (large_ff ? 5'd15 : 5'd7);
   assign lim_s     = signed'({5'b0, lim});
   assign v_s       = signed'({2'b0, req_ff.vpos});
   assign h_s       = signed'({2'b0, req_ff.hpos});
   assign y_calc    = signed'({{2{rdata_ff >= Y_WRAP}}, rdata_ff}) + 10'sd1;
   assign dy        = v_s - y_ff;
   assign keep      = (mode == SPR_MODE1) ? CNT_W'(MODE1_KEEP) : CNT_W'(LINE_SPRITES);
   assign slot      = count_ff[SLOT_W-1:0];
   assign sel       = pix_i_ff[SLOT_W-1:0];
   assign x_store   = signed'({2'b0, x_ff}) - (rdata_ff[7] ? 10'sd32 : 10'sd0);

   // mode 2 color table: one byte per line of each entry
   assign ct_addr = (attr_base_ff & CT_MASK) + ADDR_W'({index_ff, 4'b0})
                  + ADDR_W'(dy[4:0]);

   // pixel test against the selected held sprite
   assign x_sel  = obj_x_ff[sel];
   assign dx     = h_s - x_sel;
   assign dy_sel = v_s - obj_y_ff[sel];
   assign px     = zoom_ff ? dx[4:1] : dx[3:0];
   assign py     = zoom_ff ? dy_sel[4:1] : dy_sel[3:0];
   assign pyl    = (zoom_ff || large_ff) ? py : {1'b0, py[2:0]};
   assign pat_addr = pat_base_ff + ADDR_W'({obj_pat_ff[sel], 3'b0})
                   + ADDR_W'({px[3], 4'b0}) + ADDR_W'(pyl);

   always_comb begin
      case (cmd.rd_sel)
         RD_ATTR_Y:      rd_addr = scan_addr_ff;
         RD_ATTR_X:      rd_addr = scan_addr_ff + ADDR_W'(1);
         RD_ATTR_PAT:    rd_addr = scan_addr_ff + ADDR_W'(2);
         RD_ATTR_COL:    rd_addr = scan_addr_ff + ADDR_W'(3);
         RD_COLOR_TABLE: rd_addr = ct_addr;
         RD_PATTERN:     rd_addr = pat_addr;
         default:        rd_addr = pat_addr;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         video_mem[req_ff.mem_address[MEM_AW-1:0]] <= req_ff.mem_data;
      end
      rdata_ff <= video_mem[rd_addr[MEM_AW-1:0] & addr_mask[MEM_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_mode_ff <= '0;
         zoom_ff         <= 1'b0;
         large_ff        <= 1'b0;
         off_ff          <= 1'b0;
         attr_base_ff    <= '0;
         pat_base_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DISPLAY_MODE:   display_mode_ff <= csr_wdata[4:0];
            CSR_ZOOM_ENABLE:    zoom_ff         <= csr_wdata[0];
            CSR_LARGE_SIZE:     large_ff        <= csr_wdata[0];
            CSR_SPRITES_OFF:    off_ff          <= csr_wdata[0];
            CSR_ATTRIBUTE_BASE: attr_base_ff    <= csr_wdata;
            CSR_PATTERN_BASE:   pat_base_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // payload registers of the scan and pixel work
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.scan_start) begin
         index_ff     <= '0;
         scan_addr_ff <= attr_base_ff &
                         ((mode == SPR_MODE1) ? ATTR_MASK_M1 : ATTR_MASK_M2);
      end else if (cmd.scan_next) begin
         index_ff     <= index_ff + IDX_W'(1);
         scan_addr_ff <= (scan_addr_ff + ADDR_W'(4)) & addr_mask;
      end
      if (cmd.cap_y) begin
         y_ff    <= y_calc;
         yend_ff <= rdata_ff == ((mode == SPR_MODE1) ? END_Y_M1 : END_Y_M2);
      end
      if (cmd.cap_x) begin
         x_ff <= rdata_ff;
      end
      if (cmd.cap_pat) begin
         pat_ff <= large_ff ? (rdata_ff & 8'hfc) : rdata_ff;
      end
      if (cmd.store_obj) begin
         obj_x_ff[slot]   <= x_store;
         obj_y_ff[slot]   <= y_ff;
         obj_pat_ff[slot] <= pat_ff;
         obj_col_ff[slot] <= rdata_ff[3:0];
      end
      if (cmd.pix_mark) begin
         px_bit_ff <= px[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pix_i_ff     <= '0;
         color_ff     <= '0;
         collision_ff <= 1'b0;
         overflow_ff  <= 1'b0;
         ovf_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_req) begin
            pix_i_ff <= '0;
            color_ff <= '0;
         end else if (cmd.pix_next) begin
            pix_i_ff <= pix_i_ff + CNT_W'(1);
         end
         if (cmd.take_color) begin
            color_ff <= obj_col_ff[sel];
         end
         if (cmd.scan_start) begin
            count_ff <= '0;
         end else if (cmd.store_obj) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.set_coll) begin
            collision_ff <= 1'b1;
         end
         if (cmd.set_ovf) begin
            overflow_ff <= 1'b1;
            ovf_idx_ff  <= 5'(index_ff);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.color          <= color_ff;
         rsp_ff.collision      <= collision_ff;
         rsp_ff.overflow       <= overflow_ff;
         rsp_ff.overflow_index <= ovf_idx_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      sts.kind        = req_ff.kind;
      sts.mode        = mode;
      sts.sprites_off = off_ff;
      sts.end_hit     = yend_ff;
      sts.in_range    = (v_s >= y_ff) && (v_s <= y_ff + lim_s);
      sts.full        = count_ff == keep;
      sts.last_entry  = index_ff == IDX_W'(TABLE_ENTRIES - 1);
      sts.pix_done    = pix_i_ff == count_ff;
      sts.pix_hit     = (h_s >= x_sel) && (h_s <= x_sel + lim_s);
      sts.opaque      = rdata_ff[3'd7 - px_bit_ff];
      sts.color_nz    = color_ff != 4'd0;
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

endmodule

@@ hdl/sprite_line_select_and_render.sv @@
// sprite unit: one request transfer in, one result transfer out, per item
// usage: configuration is written through csr_we/csr_index/csr_wdata while the
//   block is idle; each request transfer carries a kind (memory write, line
//   scan, pixel query) and returns exactly one result transfer with the pixel
//   color and the sticky collision and overflow flags.
// sequencing: a pixel query walks the held sprites, reading a pattern byte for
//   each sprite on the pixel, and a collision ends it early; a line scan reads
//   the attribute entries in order and, in mode 2, a color table byte for each
//   kept sprite. the result becomes valid in the same cycle that the next
//   request can be taken. the single read port of the video memory is walked
//   a byte at a time by the controller.
// throughput: one item at a time; req_ready is high only while the controller
//   is idle, and the next request is taken while a result still waits.
// reset: synchronous; clears configuration, flags, held sprite count and the
//   result valid flag. result data and video memory contents are not cleared.
// stall: a result held in the output register waits for rsp_ready; a finished
//   item whose result cannot yet be loaded waits until that register frees.
module sprite_line_select_and_render (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  slsr_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output slsr_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [slsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [slsr_pkg::ADDR_W-1:0]    csr_wdata
);
   import slsr_pkg::*;

   cmd_type    cmd;
   status_type sts;

   slsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   slsr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in progress");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.overflow |=> !(rsp_valid && !rsp_data.overflow))
      else $error("overflow flag cleared");

   a_collision_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.collision |=> !(rsp_valid && !rsp_data.collision))
      else $error("collision flag cleared");
`endif

endmodule
